// File: rtl/hsfd_pkg.sv
`default_nettype none
package hsfd_pkg;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam int TEMP_SCALE  = 17500;
   localparam int HUM_SCALE   = 10000;
   localparam int TEMP_OFFSET = 4500;

   // completed reply handed from the frame tracker to the scaler
   typedef struct packed {
      logic        kind;
      logic        mismatch;
      logic [15:0] first_word;
      logic [15:0] second_word;
   } rec_type;

   // decoded result
   typedef struct packed {
      logic               kind;
      logic               status;
      logic signed [14:0] temperature_centi;
      logic [13:0]        humidity_centi;
      logic [15:0]        device_id;
   } res_type;

   // CRC-8, MSB first, no reflection, no final xor
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: rtl/hsfd_frame.sv
`default_nettype none
module hsfd_frame
   import hsfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_valid,
   output logic            byte_ready,
   input  wire logic       command,
   input  wire logic [7:0] data_byte,
   input  wire logic       frame_start,
   output logic            rec_valid,
   input  wire logic       rec_ready,
   output rec_type         rec
);

   localparam logic [2:0] POS_W1_HI   = 3'd0;
   localparam logic [2:0] POS_W1_LO   = 3'd1;
   localparam logic [2:0] POS_CRC1    = 3'd2;
   localparam logic [2:0] POS_W2_HI   = 3'd3;
   localparam logic [2:0] POS_W2_LO   = 3'd4;
   localparam logic [2:0] POS_CRC2    = 3'd5;
   localparam logic [2:0] POS_LAST_ID = POS_CRC1;
   localparam logic [2:0] POS_LAST_MS = POS_CRC2;

   logic [7:0]  crc_ff, crc_in;
   logic [2:0]  pos_ff, pos_in;
   logic        kind_ff, kind_in;
   logic        mis_ff, mis_in;
   logic [15:0] word1_ff, word1_in;
   logic [15:0] word2_ff, word2_in;
   logic        rec_valid_ff, rec_valid_in;
   rec_type     rec_ff, rec_in;

   logic        accept;
   logic        restart;
   logic [2:0]  cur_pos;
   logic [7:0]  cur_crc;
   logic        done;

   assign byte_ready = !rec_valid_ff || rec_ready;
   assign accept     = byte_valid && byte_ready;
   assign rec_valid  = rec_valid_ff;
   assign rec        = rec_ff;

   always_comb begin
      restart  = frame_start || (pos_ff == POS_W1_HI) || (pos_ff > POS_CRC2);
      cur_pos  = restart ? POS_W1_HI : pos_ff;
      cur_crc  = restart ? CRC_INIT : crc_ff;
      mis_in   = restart ? 1'b0 : mis_ff;
      kind_in  = restart ? command : kind_ff;
      crc_in   = crc8_byte(cur_crc, data_byte);
      word1_in = word1_ff;
      word2_in = word2_ff;
      unique case (cur_pos)
         POS_W1_HI: word1_in[15:8] = data_byte;
         POS_W1_LO: word1_in[7:0]  = data_byte;
         POS_W2_HI: word2_in[15:8] = data_byte;
         POS_W2_LO: word2_in[7:0]  = data_byte;
         POS_CRC1, POS_CRC2: begin
            if (cur_crc != data_byte) begin
               mis_in = 1'b1;
            end
            crc_in = CRC_INIT;
         end
         default: ;
      endcase
      done   = cur_pos == (kind_in ? POS_LAST_ID : POS_LAST_MS);
      pos_in = done ? POS_W1_HI : cur_pos + 3'd1;

      rec_in.kind        = kind_in;
      rec_in.mismatch    = mis_in;
      rec_in.first_word  = word1_in;
      rec_in.second_word = word2_in;

      rec_valid_in = rec_valid_ff && !rec_ready;
      if (accept && done) begin
         rec_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         pos_ff       <= POS_W1_HI;
         kind_ff      <= 1'b0;
         mis_ff       <= 1'b0;
         word1_ff     <= '0;
         word2_ff     <= '0;
         rec_valid_ff <= 1'b0;
      end else begin
         rec_valid_ff <= rec_valid_in;
         if (accept) begin
            crc_ff   <= crc_in;
            pos_ff   <= pos_in;
            kind_ff  <= kind_in;
            mis_ff   <= mis_in;
            word1_ff <= word1_in;
            word2_ff <= word2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && done) begin
         rec_ff <= rec_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/hsfd_scale.sv
`default_nettype none
module hsfd_scale
   import hsfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    rec_valid,
   output logic         rec_ready,
   input  wire rec_type rec,
   output logic         res_valid,
   input  wire logic    res_ready,
   output res_type      res
);

   // floor(x / 65535) for x below 2^31: one correction step is enough
   function automatic logic [14:0] div65535(input logic [30:0] x);
      logic [14:0] q0;
      logic [16:0] r0;
      q0 = x[30:16];
      r0 = {1'b0, x[15:0]} + {2'b00, q0};
      return (r0 >= 17'd65535) ? q0 + 15'd1 : q0;
   endfunction

   logic        mul_valid_ff, mul_valid_in;
   logic        mul_kind_ff;
   logic        mul_mis_ff;
   logic [15:0] mul_word_ff;
   logic [30:0] mul_t_ff;
   logic [30:0] mul_h_ff;
   logic        res_valid_ff, res_valid_in;
   res_type     res_ff, res_in;

   logic        mul_ready;
   logic        out_ready;
   logic        mul_load;
   logic        out_load;
   logic [14:0] q_t;
   logic [14:0] q_h;

   assign out_ready = !res_valid_ff || res_ready;
   assign mul_ready = !mul_valid_ff || out_ready;
   assign rec_ready = mul_ready;
   assign mul_load  = rec_valid && mul_ready;
   assign out_load  = mul_valid_ff && out_ready;
   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   always_comb begin
      q_t = div65535(mul_t_ff);
      q_h = div65535(mul_h_ff);

      res_in.kind              = mul_kind_ff;
      res_in.status            = mul_mis_ff;
      res_in.temperature_centi = '0;
      res_in.humidity_centi    = '0;
      res_in.device_id         = '0;
      if (!mul_mis_ff) begin
         if (mul_kind_ff) begin
            res_in.device_id = mul_word_ff;
         end else begin
            res_in.temperature_centi = $signed(q_t - 15'(TEMP_OFFSET));
            res_in.humidity_centi    = q_h[13:0];
         end
      end

      mul_valid_in = mul_load || (mul_valid_ff && !out_ready);
      res_valid_in = out_load || (res_valid_ff && !res_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_load) begin
         mul_kind_ff <= rec.kind;
         mul_mis_ff  <= rec.mismatch;
         mul_word_ff <= rec.first_word;
         mul_t_ff    <= 31'(rec.first_word) * 31'(TEMP_SCALE);
         mul_h_ff    <= 31'(rec.second_word) * 31'(HUM_SCALE);
      end
      if (out_load) begin
         res_ff <= res_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/humidity_sensor_frame_decoder.sv
`default_nettype none
// Sensor reply decoder. Takes one reply byte per cycle on req_ while
// req_tready is high and checks the CRC-8 (poly 0x31, init 0xFF) of every
// word on the fly. A measurement reply is six bytes, an ID reply three;
// req_tuser[1] marks the first byte of a reply and drops any partial one.
// After the last byte the result passes through the frame, multiply and
// output registers to rsp_; the per-byte CRC is unrolled, so the byte rate
// is one per cycle while req_tready is high, with no gaps between replies.
// Temperature and humidity come out in hundredths, scaled by a multiply and
// an exact divide by 65535. On a CRC mismatch status is set and all values
// read zero. A stalled rsp_ side fills all three registers before req_tready drops.
module humidity_sensor_frame_decoder
   import hsfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte[7:0]
   input  wire logic [1:0]  req_tuser,   // command[0], frame_start[1]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // status[0], temperature_centi[15:1],
                                         // humidity_centi[29:16], device_id[45:30], zero[47:46]
   output logic             rsp_tuser    // reply_kind
);

   logic    rec_valid;
   logic    rec_ready;
   rec_type rec;
   res_type res;

   hsfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .byte_ready  (req_tready),
      .command     (req_tuser[0]),
      .data_byte   (req_tdata),
      .frame_start (req_tuser[1]),
      .rec_valid   (rec_valid),
      .rec_ready   (rec_ready),
      .rec         (rec)
   );

   hsfd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (rec_valid),
      .rec_ready (rec_ready),
      .rec       (rec),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res       (res)
   );

   assign rsp_tuser = res.kind;
   assign rsp_tdata = {2'b00, res.device_id, res.humidity_centi,
                       res.temperature_centi, res.status};

endmodule
`default_nettype wire
